[src/hrro_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrro_pkg
// Shared constants, codes and control structs of the history ring.
// ----------------------------------------------------------------------------
package hrro_pkg;

  localparam int DEPTH      = 4096;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int CAP_W      = 13;
  localparam int CNT_W      = 32;
  localparam int LOST_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int STEP_W     = $clog2(CNT_W);

  localparam logic [LOST_W-1:0] LOST_MAX  = 16'hFFFF;
  localparam logic [CAP_W-1:0]  CAP_RESET = 13'd4096;
  localparam logic [CAP_W-1:0]  CAP_LIMIT = CAP_W'(DEPTH);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READER_ENABLE = 1'd1;

  typedef struct packed {
    logic write;
    logic catchup;
    logic fetch;
    logic load;
    logic sync_start_w;
    logic sync_start_r;
    logic sync_load_w;
    logic sync_load_r;
  } dp_cmd_t;

  typedef struct packed {
    logic resync_pend;
    logic rem_done;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

[src/hrro_rem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrro_rem
// Bit-serial restoring remainder: counter value modulo capacity in use.
// ----------------------------------------------------------------------------
module hrro_rem (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [hrro_pkg::CNT_W-1:0]       dividend,
  input  wire logic [hrro_pkg::CAP_W-1:0]       divisor,
  output logic                                  done,
  output logic      [hrro_pkg::SLOT_W-1:0]      rem
);

  logic [hrro_pkg::CNT_W-1:0]  x_r, x_nxt;
  logic [hrro_pkg::CAP_W-1:0]  d_r, d_nxt;
  logic [hrro_pkg::CAP_W-1:0]  r_r, r_nxt;
  logic [hrro_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [hrro_pkg::CAP_W:0]    trial;

  always_comb begin
    x_nxt    = x_r;
    d_nxt    = d_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r, x_r[hrro_pkg::CNT_W-1]};
    if (start) begin
      x_nxt    = dividend;
      d_nxt    = divisor;
      r_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        trial = trial - {1'b0, d_r};
      end
      r_nxt   = trial[hrro_pkg::CAP_W-1:0];
      x_nxt   = {x_r[hrro_pkg::CNT_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == hrro_pkg::STEP_W'(hrro_pkg::CNT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    d_r   <= d_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r[hrro_pkg::SLOT_W-1:0];

endmodule
`default_nettype wire

[src/hrro_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrro_dp
// Datapath: history memory, stream counters, wrapped slot pointers,
// overrun counter, configuration registers and output register.
// ----------------------------------------------------------------------------
module hrro_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [hrro_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hrro_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [hrro_pkg::BYTE_W-1:0]         in_data_byte,
  input  wire hrro_pkg::dp_cmd_t                   cmd,
  output hrro_pkg::dp_sts_t                        sts,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic      [hrro_pkg::BYTE_W-1:0]         out_read_byte,
  output logic                                     out_byte_valid,
  output logic      [hrro_pkg::LOST_W-1:0]         out_lost_bytes,
  output logic      [hrro_pkg::CNT_W-1:0]          out_cursor_position
);

  function automatic logic [hrro_pkg::SLOT_W-1:0] adv_slot(
    input logic [hrro_pkg::SLOT_W-1:0] slot,
    input logic [hrro_pkg::CAP_W-1:0]  cap
  );
    logic [hrro_pkg::CAP_W-1:0] inc;
    inc = hrro_pkg::CAP_W'(slot) + 1'b1;
    return (inc >= cap) ? '0 : hrro_pkg::SLOT_W'(inc);
  endfunction

  logic [hrro_pkg::BYTE_W-1:0] mem_r [hrro_pkg::DEPTH];
  logic [hrro_pkg::BYTE_W-1:0] rdata_r;

  logic [hrro_pkg::CNT_W-1:0]  tw_r, tw_nxt;
  logic [hrro_pkg::CNT_W-1:0]  rp_r, rp_nxt;
  logic [hrro_pkg::LOST_W-1:0] lost_r, lost_nxt;
  logic [hrro_pkg::SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [hrro_pkg::SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [hrro_pkg::CAP_W-1:0]  cap_r, cap_nxt;
  logic                        ren_r, ren_nxt;
  logic                        resync_r, resync_nxt;
  logic                        hit_r, hit_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic [hrro_pkg::BYTE_W-1:0] obyte_r;
  logic                        obvalid_r;
  logic [hrro_pkg::LOST_W-1:0] olost_r;
  logic [hrro_pkg::CNT_W-1:0]  ocursor_r;

  logic [hrro_pkg::CAP_W-1:0]  cap_use;
  logic [hrro_pkg::CNT_W-1:0]  cap_wide;
  logic                        cap_nz;
  logic                        active;
  logic [hrro_pkg::CNT_W-1:0]  first;
  logic [hrro_pkg::CNT_W-1:0]  missed;
  logic [hrro_pkg::LOST_W:0]   lost_sum;
  logic                        lost_sat;
  logic                        behind;
  logic                        avail;
  logic                        rem_done;
  logic [hrro_pkg::SLOT_W-1:0] rem;

  assign cap_use  = (cap_r > hrro_pkg::CAP_LIMIT) ? hrro_pkg::CAP_LIMIT : cap_r;
  assign cap_wide = hrro_pkg::CNT_W'(cap_use);
  assign cap_nz   = (cap_use != '0);
  assign active   = ren_r && cap_nz;
  assign first    = (tw_r > cap_wide) ? (tw_r - cap_wide) : '0;
  assign missed   = first - rp_r;
  assign lost_sum = {1'b0, lost_r} + {1'b0, missed[hrro_pkg::LOST_W-1:0]};
  assign lost_sat = (|missed[hrro_pkg::CNT_W-1:hrro_pkg::LOST_W]) || lost_sum[hrro_pkg::LOST_W];
  assign behind   = active && (rp_r < first);
  assign avail    = active && (rp_r < tw_r);

  hrro_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sync_start_w || cmd.sync_start_r),
    .dividend (cmd.sync_start_r ? rp_r : tw_r),
    .divisor  (cap_use),
    .done     (rem_done),
    .rem      (rem)
  );

  always_comb begin
    tw_nxt      = tw_r;
    rp_nxt      = rp_r;
    lost_nxt    = lost_r;
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    cap_nxt     = cap_r;
    ren_nxt     = ren_r;
    resync_nxt  = resync_r;
    hit_nxt     = hit_r;
    ovalid_nxt  = ovalid_r;

    if (cmd.write && cap_nz) begin
      tw_nxt      = tw_r + 1'b1;
      wr_slot_nxt = (tw_r == '1) ? '0 : adv_slot(wr_slot_r, cap_use);
    end
    if (cmd.catchup && behind) begin
      lost_nxt    = lost_sat ? hrro_pkg::LOST_MAX : lost_sum[hrro_pkg::LOST_W-1:0];
      rp_nxt      = first;
      rd_slot_nxt = wr_slot_r;
    end
    if (cmd.fetch) begin
      hit_nxt = avail;
      if (avail) begin
        rp_nxt      = rp_r + 1'b1;
        rd_slot_nxt = (rp_r == '1) ? '0 : adv_slot(rd_slot_r, cap_use);
      end
    end
    if (cmd.sync_load_w) begin
      wr_slot_nxt = rem;
    end
    if (cmd.sync_load_r) begin
      rd_slot_nxt = rem;
    end
    if (cmd.sync_start_w) begin
      resync_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      unique case (cfg_index)
        hrro_pkg::REG_CAPACITY: begin
          cap_nxt    = cfg_data[hrro_pkg::CAP_W-1:0];
          resync_nxt = 1'b1;
        end
        hrro_pkg::REG_READER_ENABLE: begin
          ren_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
    if (cmd.load) begin
      ovalid_nxt = 1'b1;
    end else if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && cap_nz) begin
      mem_r[wr_slot_r] <= in_data_byte;
    end
    if (cmd.fetch) begin
      rdata_r <= mem_r[rd_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    if (cmd.load) begin
      obyte_r   <= hit_r ? rdata_r : '0;
      obvalid_r <= hit_r;
      olost_r   <= lost_r;
      ocursor_r <= rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r      <= '0;
      rp_r      <= '0;
      lost_r    <= '0;
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      cap_r     <= hrro_pkg::CAP_RESET;
      ren_r     <= 1'b1;
      resync_r  <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      tw_r      <= tw_nxt;
      rp_r      <= rp_nxt;
      lost_r    <= lost_nxt;
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      cap_r     <= cap_nxt;
      ren_r     <= ren_nxt;
      resync_r  <= resync_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  assign sts.resync_pend = resync_r;
  assign sts.rem_done    = rem_done;
  assign sts.out_free    = !ovalid_r || !out_stall;

  assign out_valid           = ovalid_r;
  assign out_read_byte       = obyte_r;
  assign out_byte_valid      = obvalid_r;
  assign out_lost_bytes      = olost_r;
  assign out_cursor_position = ocursor_r;

endmodule
`default_nettype wire

[src/hrro_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrro_ctrl
// Controller: accepts transactions, sequences reads and pointer resync.
// ----------------------------------------------------------------------------
module hrro_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_command,
  output logic                    in_stall,
  input  wire hrro_pkg::dp_sts_t  sts,
  output hrro_pkg::dp_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SYNC_W = 6'b000010,
    S_SYNC_R = 6'b000100,
    S_CATCH  = 6'b001000,
    S_FETCH  = 6'b010000,
    S_LOAD   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (sts.resync_pend) begin
          cmd.sync_start_w = 1'b1;
          state_nxt        = S_SYNC_W;
        end else begin
          in_stall = 1'b0;
          if (in_valid) begin
            if (in_command == hrro_pkg::CMD_READ) begin
              state_nxt = S_CATCH;
            end else begin
              cmd.write = 1'b1;
            end
          end
        end
      end
      S_SYNC_W: begin
        if (sts.rem_done) begin
          cmd.sync_load_w  = 1'b1;
          cmd.sync_start_r = 1'b1;
          state_nxt        = S_SYNC_R;
        end
      end
      S_SYNC_R: begin
        if (sts.rem_done) begin
          cmd.sync_load_r = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_CATCH: begin
        cmd.catchup = 1'b1;
        state_nxt   = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[src/history_ring_with_reader_overrun.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// history_ring_with_reader_overrun
// Byte history ring with one reader cursor and a saturating overrun count.
// ----------------------------------------------------------------------------
// Write transaction: one per cycle while idle and no resync is pending.
// Read transaction: after acceptance the catch-up, fetch and load steps run in
//   order; input stalls until the load, which waits while the output stalls.
// Capacity write: slot pointers re-derived by two serial remainders, write
//   then read; input stalled until both are done.
// Reset: counters and pointers cleared, capacity 4096, reader on; memory kept.
// ----------------------------------------------------------------------------
module history_ring_with_reader_overrun (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [hrro_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hrro_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_command,
  input  wire logic [hrro_pkg::BYTE_W-1:0]      in_data_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [hrro_pkg::BYTE_W-1:0]      out_read_byte,
  output logic                                  out_byte_valid,
  output logic      [hrro_pkg::LOST_W-1:0]      out_lost_bytes,
  output logic      [hrro_pkg::CNT_W-1:0]       out_cursor_position
);

  hrro_pkg::dp_cmd_t cmd;
  hrro_pkg::dp_sts_t sts;

  hrro_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  hrro_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_data_byte        (in_data_byte),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_read_byte       (out_read_byte),
    .out_byte_valid      (out_byte_valid),
    .out_lost_bytes      (out_lost_bytes),
    .out_cursor_position (out_cursor_position)
  );

endmodule
`default_nettype wire
